FILE: hw/rtl/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the peer liveness table.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned NumEntriesDef = 32;

  localparam int unsigned MacW   = 48;
  localparam int unsigned NameW  = 64;
  localparam int unsigned EtypeW = 16;
  localparam int unsigned BeatW  = 32;
  localparam int unsigned WinW   = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [WinW-1:0] LiveWindowRst = 8'd15;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FK_START     = 2'd0,
    FK_HEARTBEAT = 2'd1,
    FK_TALK      = 2'd2,
    FK_OTHER     = 2'd3
  } frame_kind_e;

  typedef enum logic [KindW-1:0] {
    KIND_IGNORED    = 4'd0,
    KIND_REFRESHED  = 4'd1,
    KIND_ADDED      = 4'd2,
    KIND_ADDED_REPLY = 4'd3,
    KIND_FULL       = 4'd4,
    KIND_FOUND      = 4'd5,
    KIND_MISS       = 4'd6,
    KIND_LIST_ENTRY = 4'd7,
    KIND_LIST_EMPTY = 4'd8
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_MAC     = 2'd0,
    REG_ETHERTYPE   = 2'd1,
    REG_LIVE_WINDOW = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    SCAN_HEARTBEAT,
    SCAN_LOOKUP,
    SCAN_LIST
  } scan_mode_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_IGNORED,
    EMIT_REFRESH,
    EMIT_FOUND,
    EMIT_MISS,
    EMIT_LIST_PUSH,
    EMIT_LIST_END,
    EMIT_APPEND
  } emit_e;

  typedef struct packed {
    logic [NameW-1:0] name_hi;
    logic [NameW-1:0] name_lo;
    logic [MacW-1:0]  mac;
    logic [BeatW-1:0] beat;
  } entry_t;

  typedef struct packed {
    logic       tick;
    logic       latch;
    logic       rd_en;
    emit_e      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic is_hb;
    logic more;
    logic name_hit;
    logic live;
  } dp_stat_t;

endpackage

FILE: hw/rtl/plt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/plt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_datapath
// Entry store, seconds counter, configuration, entry checks and result regs.
// ----------------------------------------------------------------------------
module plt_datapath #(
  parameter int unsigned NumEntries = 32,
  localparam int unsigned CntW  = $clog2(NumEntries + 1),
  localparam int unsigned AddrW = (NumEntries > 1) ? $clog2(NumEntries) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plt_pkg::dp_cmd_t              cmd_i,
  output plt_pkg::dp_stat_t             stat_o,
  input  logic [CntW-1:0]               scan_idx_i,
  input  logic [AddrW-1:0]              chk_idx_i,
  input  logic [1:0]                    frame_kind_i,
  input  logic [plt_pkg::EtypeW-1:0]    ethertype_i,
  input  logic [plt_pkg::MacW-1:0]      src_mac_i,
  input  logic [plt_pkg::NameW-1:0]     name_hi_i,
  input  logic [plt_pkg::NameW-1:0]     name_lo_i,
  input  logic                          cfg_we_i,
  input  logic [plt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [plt_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          res_valid_o,
  output logic [plt_pkg::KindW-1:0]     kind_o,
  output logic [plt_pkg::MacW-1:0]      peer_mac_o,
  output logic [plt_pkg::NameW-1:0]     peer_name_hi_o,
  output logic [plt_pkg::NameW-1:0]     peer_name_lo_o,
  output logic [plt_pkg::BeatW-1:0]     beat_second_o,
  output logic                          last_o
);

  import plt_pkg::*;

  function automatic logic names_match(input logic [2*NameW-1:0] a,
                                       input logic [2*NameW-1:0] b);
    logic       ok;
    logic       stop;
    logic [7:0] ab;
    logic [7:0] bb;
    ok   = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < 16; i++) begin
      ab = a[2*NameW-1-8*i -: 8];
      bb = b[2*NameW-1-8*i -: 8];
      if ((ab != bb) && !stop) begin
        ok = 1'b0;
      end
      if ((ab == bb) && (ab == 8'd0)) begin
        stop = 1'b1;
      end
    end
    return ok;
  endfunction

  // configuration and counters
  logic [MacW-1:0]   own_mac_q;
  logic [EtypeW-1:0] etype_q;
  logic [WinW-1:0]   window_q;
  logic [BeatW-1:0]  now_q, now_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              res_valid_q, res_valid_d;
  logic              pend_vld_q, pend_vld_d;

  // latched item
  logic [1:0]        fk_q;
  logic [EtypeW-1:0] et_q;
  logic [MacW-1:0]   src_q;
  logic [NameW-1:0]  nh_q;
  logic [NameW-1:0]  nl_q;

  // result and pending list entry
  entry_t            pend_q;
  logic              pend_load;
  entry_t            res_ent_q, res_ent_d;
  logic [KindW-1:0]  res_kind_q, res_kind_d;
  logic              res_last_q, res_last_d;

  // store
  logic              we;
  logic [AddrW-1:0]  waddr;
  entry_t            wdata;
  entry_t            rd;
  entry_t            fresh;
  entry_t            added;

  logic              full;
  logic              name_ok;
  logic              live;
  logic [BeatW-1:0]  age;

  plt_ram #(
    .Width($bits(entry_t)),
    .Depth(NumEntries)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(scan_idx_i[AddrW-1:0]),
    .rdata_o(rd)
  );

  assign full    = (count_q >= CntW'(NumEntries));
  assign name_ok = names_match({rd.name_hi, rd.name_lo}, {nh_q, nl_q});
  assign age     = now_q - rd.beat;
  assign live    = (age <= {{(BeatW-WinW){1'b0}}, window_q});

  always_comb begin
    stat_o.drop     = (et_q != etype_q) || (src_q == own_mac_q) || (fk_q == FK_TALK);
    stat_o.is_hb    = (fk_q == FK_HEARTBEAT);
    stat_o.more     = (scan_idx_i < count_q);
    stat_o.name_hit = name_ok;
    stat_o.live     = live;
  end

  always_comb begin
    fresh      = rd;
    fresh.beat = now_q;
    added      = '{name_hi: nh_q, name_lo: nl_q, mac: src_q, beat: now_q};

    res_valid_d = 1'b0;
    res_kind_d  = KIND_IGNORED;
    res_ent_d   = '0;
    res_last_d  = 1'b1;
    pend_vld_d  = pend_vld_q;
    pend_load   = 1'b0;
    count_d     = count_q;
    now_d       = now_q;
    we          = 1'b0;
    waddr       = chk_idx_i;
    wdata       = fresh;

    if (cmd_i.tick) begin
      now_d = now_q + 32'd1;
    end
    if (cmd_i.latch) begin
      pend_vld_d = 1'b0;
    end

    case (cmd_i.emit)
      EMIT_IGNORED: begin
        res_valid_d = 1'b1;
      end
      EMIT_REFRESH: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_REFRESHED;
        res_ent_d   = fresh;
        we          = 1'b1;
      end
      EMIT_FOUND: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_FOUND;
        res_ent_d   = rd;
      end
      EMIT_MISS: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_MISS;
      end
      EMIT_LIST_PUSH: begin
        res_valid_d = pend_vld_q;
        res_kind_d  = KIND_LIST_ENTRY;
        res_ent_d   = pend_q;
        res_last_d  = 1'b0;
        pend_load   = 1'b1;
        pend_vld_d  = 1'b1;
      end
      EMIT_LIST_END: begin
        res_valid_d = 1'b1;
        pend_vld_d  = 1'b0;
        if (pend_vld_q) begin
          res_kind_d = KIND_LIST_ENTRY;
          res_ent_d  = pend_q;
        end else begin
          res_kind_d = KIND_LIST_EMPTY;
        end
      end
      EMIT_APPEND: begin
        res_valid_d = 1'b1;
        if (full) begin
          res_kind_d = KIND_FULL;
          res_ent_d  = '{name_hi: nh_q, name_lo: nl_q, mac: src_q, beat: '0};
        end else begin
          res_kind_d = (fk_q == FK_HEARTBEAT) ? KIND_ADDED : KIND_ADDED_REPLY;
          res_ent_d  = added;
          we         = 1'b1;
          waddr      = count_q[AddrW-1:0];
          wdata      = added;
          count_d    = count_q + CntW'(1);
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q   <= '0;
      etype_q     <= '0;
      window_q    <= LiveWindowRst;
      now_q       <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      pend_vld_q  <= 1'b0;
    end else begin
      now_q       <= now_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      pend_vld_q  <= pend_vld_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OWN_MAC:     own_mac_q <= cfg_data_i[MacW-1:0];
          REG_ETHERTYPE:   etype_q   <= cfg_data_i[EtypeW-1:0];
          REG_LIVE_WINDOW: window_q  <= cfg_data_i[WinW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      fk_q  <= frame_kind_i;
      et_q  <= ethertype_i;
      src_q <= src_mac_i;
      nh_q  <= name_hi_i;
      nl_q  <= name_lo_i;
    end
    if (pend_load) begin
      pend_q <= rd;
    end
    if (res_valid_d) begin
      res_kind_q <= res_kind_d;
      res_ent_q  <= res_ent_d;
      res_last_q <= res_last_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign kind_o         = res_kind_q;
  assign peer_mac_o     = res_ent_q.mac;
  assign peer_name_hi_o = res_ent_q.name_hi;
  assign peer_name_lo_o = res_ent_q.name_lo;
  assign beat_second_o  = res_ent_q.beat;
  assign last_o         = res_last_q;

endmodule

FILE: hw/rtl/plt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer: takes commands, walks the table one entry per cycle.
// ----------------------------------------------------------------------------
module plt_ctrl #(
  parameter int unsigned NumEntries = 32,
  localparam int unsigned CntW  = $clog2(NumEntries + 1),
  localparam int unsigned AddrW = (NumEntries > 1) ? $clog2(NumEntries) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  plt_pkg::cmd_e      cmd_i,
  output logic               busy_o,
  output plt_pkg::dp_cmd_t   dp_cmd_o,
  input  plt_pkg::dp_stat_t  stat_i,
  output logic [CntW-1:0]    scan_idx_o,
  output logic [AddrW-1:0]   chk_idx_o
);

  import plt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_APPEND
  } state_e;

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [AddrW-1:0] chk_idx_q, chk_idx_d;
  scan_mode_e       mode;
  logic             hit;

  always_comb begin
    case (cmd_q)
      CMD_LOOKUP: mode = SCAN_LOOKUP;
      CMD_LIST:   mode = SCAN_LIST;
      default:    mode = SCAN_HEARTBEAT;
    endcase
  end

  always_comb begin
    case (mode)
      SCAN_HEARTBEAT: hit = stat_i.name_hit;
      SCAN_LOOKUP:    hit = stat_i.name_hit && stat_i.live;
      SCAN_LIST:      hit = stat_i.live;
      default:        hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    dp_cmd_o  = '{tick: 1'b0, latch: 1'b0, rd_en: 1'b0, emit: EMIT_NONE};

    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (start_i) begin
          if (cmd_i == CMD_TICK) begin
            dp_cmd_o.tick = 1'b1;
          end else begin
            dp_cmd_o.latch = 1'b1;
            cmd_d          = cmd_i;
            state_d        = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        case (cmd_q)
          CMD_FRAME: begin
            if (stat_i.drop) begin
              dp_cmd_o.emit = EMIT_IGNORED;
              state_d       = ST_IDLE;
            end else if (stat_i.is_hb) begin
              state_d = ST_SCAN;
            end else begin
              state_d = ST_APPEND;
            end
          end
          CMD_LOOKUP, CMD_LIST: state_d = ST_SCAN;
          default:              state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        dp_cmd_o.rd_en = stat_i.more;
        chk_vld_d      = stat_i.more;
        chk_idx_d      = idx_q[AddrW-1:0];
        if (stat_i.more) begin
          idx_d = idx_q + CntW'(1);
        end
        if (chk_vld_q && hit) begin
          case (mode)
            SCAN_HEARTBEAT: begin
              dp_cmd_o.emit = EMIT_REFRESH;
              state_d       = ST_IDLE;
            end
            SCAN_LOOKUP: begin
              dp_cmd_o.emit = EMIT_FOUND;
              state_d       = ST_IDLE;
            end
            default: dp_cmd_o.emit = EMIT_LIST_PUSH;
          endcase
        end else if (!chk_vld_q && !stat_i.more) begin
          case (mode)
            SCAN_HEARTBEAT: state_d = ST_APPEND;
            SCAN_LOOKUP: begin
              dp_cmd_o.emit = EMIT_MISS;
              state_d       = ST_IDLE;
            end
            default: begin
              dp_cmd_o.emit = EMIT_LIST_END;
              state_d       = ST_IDLE;
            end
          endcase
        end
      end
      ST_APPEND: begin
        dp_cmd_o.emit = EMIT_APPEND;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= CMD_TICK;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign scan_idx_o = idx_q;
  assign chk_idx_o  = chk_idx_q;

endmodule

FILE: hw/rtl/peer_liveness_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_liveness_table
// Table of peers refreshed by heartbeat frames, with lookup and live listing.
//
//   channel   handshake                 payload
//   command   start / busy              cmd, frame_kind, ethertype, src_mac,
//                                       name_hi, name_lo
//   result    result_valid_o strobe     kind, peer_mac, peer_name_hi/lo,
//                                       beat_second, last
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick leaves busy low. An ignored frame goes back to idle from the decide
// state and a start frame passes through the append state; a lookup, list or
// heartbeat walks the table, checking one entry per cycle out of a store with
// registered reads, and a heartbeat that finds no match then appends.
// The last result shows in the cycle busy falls and cannot be held off.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module peer_liveness_table #(
  parameter int unsigned NumEntries = plt_pkg::NumEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [1:0]                    frame_kind_i,
  input  logic [plt_pkg::EtypeW-1:0]    ethertype_i,
  input  logic [plt_pkg::MacW-1:0]      src_mac_i,
  input  logic [plt_pkg::NameW-1:0]     name_hi_i,
  input  logic [plt_pkg::NameW-1:0]     name_lo_i,
  output logic                          result_valid_o,
  output logic [plt_pkg::KindW-1:0]     kind_o,
  output logic [plt_pkg::MacW-1:0]      peer_mac_o,
  output logic [plt_pkg::NameW-1:0]     peer_name_hi_o,
  output logic [plt_pkg::NameW-1:0]     peer_name_lo_o,
  output logic [plt_pkg::BeatW-1:0]     beat_second_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [plt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [plt_pkg::CfgDataW-1:0]  cfg_data_i
);

  import plt_pkg::*;

  localparam int unsigned CntW  = $clog2(NumEntries + 1);
  localparam int unsigned AddrW = (NumEntries > 1) ? $clog2(NumEntries) : 1;

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [CntW-1:0]  scan_idx;
  logic [AddrW-1:0] chk_idx;

  assign cfg_ready_o = 1'b1;

  plt_ctrl #(
    .NumEntries(NumEntries)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd_e'(cmd_i)),
    .busy_o    (busy),
    .dp_cmd_o  (dp_cmd),
    .stat_i    (dp_stat),
    .scan_idx_o(scan_idx),
    .chk_idx_o (chk_idx)
  );

  plt_datapath #(
    .NumEntries(NumEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .scan_idx_i    (scan_idx),
    .chk_idx_i     (chk_idx),
    .frame_kind_i  (frame_kind_i),
    .ethertype_i   (ethertype_i),
    .src_mac_i     (src_mac_i),
    .name_hi_i     (name_hi_i),
    .name_lo_i     (name_lo_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (result_valid_o),
    .kind_o        (kind_o),
    .peer_mac_o    (peer_mac_o),
    .peer_name_hi_o(peer_name_hi_o),
    .peer_name_lo_o(peer_name_lo_o),
    .beat_second_o (beat_second_o),
    .last_o        (last_o)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peer liveness table.
//
// A short table of directed commands covers empty-table list and lookup,
// own-MAC, foreign-ethertype and talk frames, start and heartbeat appends,
// refresh by a name that differs only after its terminating NUL, empty and
// all-ones names. Random commands follow in four configuration phases: reset
// values, all-ones extremes, zero live window, and random settings. Frames
// draw names from a small pool so that heartbeats hit existing peers and the
// table fills up. Every accepted command is fed to a behavioral model of the
// table whose results are queued and compared field by field with each
// result strobe. Command gaps are random, with stretches of back-to-back
// transfers.
// ----------------------------------------------------------------------------
module testbench;

  import plt_pkg::*;

  localparam int unsigned NUM         = NumEntriesDef;
  localparam int unsigned POOL        = 10;
  localparam int unsigned PHASE_ITEMS = 73;
  localparam int unsigned STALL_LIMIT = 2000;

  localparam logic [127:0] NAME_ALPHA      = {40'h616C706861, 88'h0};
  localparam logic [127:0] NAME_ALPHA_TAIL = {40'h616C706861, 8'h00, 80'hDEAD_BEEF_0123_4567_89AB};
  localparam logic [127:0] NAME_ALPHB      = {40'h616C706862, 88'h0};
  localparam logic [127:0] NAME_ONES       = '1;
  localparam logic [127:0] NAME_EMPTY      = '0;

  typedef struct packed {
    cmd_e           cmd;
    frame_kind_e    fk;
    logic [15:0]    etype;
    logic [47:0]    src;
    logic [127:0]   name;
  } plt_cmd_t;

  typedef struct packed {
    kind_e          kind;
    logic [47:0]    mac;
    logic [63:0]    name_hi;
    logic [63:0]    name_lo;
    logic [31:0]    beat;
    logic           last;
  } peer_result_t;

  typedef struct packed {
    plt_cmd_t       cmd;
    logic           typed;
    peer_result_t   want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           cmd_i;
  logic [1:0]           frame_kind_i;
  logic [EtypeW-1:0]    ethertype_i;
  logic [MacW-1:0]      src_mac_i;
  logic [NameW-1:0]     name_hi_i;
  logic [NameW-1:0]     name_lo_i;
  logic                 result_valid_o;
  logic [KindW-1:0]     kind_o;
  logic [MacW-1:0]      peer_mac_o;
  logic [NameW-1:0]     peer_name_hi_o;
  logic [NameW-1:0]     peer_name_lo_o;
  logic [BeatW-1:0]     beat_second_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  // model state
  logic [63:0]    peer_name_hi [NUM];
  logic [63:0]    peer_name_lo [NUM];
  logic [47:0]    peer_mac [NUM];
  logic [31:0]    peer_beat [NUM];
  int unsigned    peer_count;
  logic [31:0]    seconds_now;
  logic [47:0]    cfg_own_mac;
  logic [15:0]    cfg_etype;
  logic [7:0]     cfg_window;

  peer_result_t   step_results [$];
  peer_result_t   expected_q [$];
  peer_result_t   oldest;
  stim_row_t      stim_rows [$];
  logic [127:0]   name_pool [POOL];
  int unsigned    name_len [POOL];
  int unsigned    error_count;
  int unsigned    stall_cycles;
  bit             back_to_back;

  peer_liveness_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .frame_kind_i   (frame_kind_i),
    .ethertype_i    (ethertype_i),
    .src_mac_i      (src_mac_i),
    .name_hi_i      (name_hi_i),
    .name_lo_i      (name_lo_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .peer_mac_o     (peer_mac_o),
    .peer_name_hi_o (peer_name_hi_o),
    .peer_name_lo_o (peer_name_lo_o),
    .beat_second_o  (beat_second_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic plt_cmd_t mk_cmd(cmd_e cmd, frame_kind_e fk, logic [15:0] etype,
                                      logic [47:0] src, logic [127:0] name);
    plt_cmd_t c;
    c.cmd   = cmd;
    c.fk    = fk;
    c.etype = etype;
    c.src   = src;
    c.name  = name;
    return c;
  endfunction

  function automatic peer_result_t blank_result(kind_e kind);
    peer_result_t r;
    r      = '0;
    r.kind = kind;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic peer_result_t entry_result(kind_e kind, int unsigned idx, logic last);
    peer_result_t r;
    r.kind    = kind;
    r.mac     = peer_mac[idx];
    r.name_hi = peer_name_hi[idx];
    r.name_lo = peer_name_lo[idx];
    r.beat    = peer_beat[idx];
    r.last    = last;
    return r;
  endfunction

  function automatic void add_row(plt_cmd_t cmd, logic typed, peer_result_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  // byte 0 sits in the top byte, compare stops at a shared NUL
  function automatic bit names_equal(logic [127:0] a, logic [127:0] b);
    int i;
    for (i = 0; i < 16; i++) begin
      if (a[127-8*i -: 8] != b[127-8*i -: 8]) return 1'b0;
      if (a[127-8*i -: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit peer_live(int unsigned idx);
    logic [31:0] age;
    age = seconds_now - peer_beat[idx];
    return age <= {24'h0, cfg_window};
  endfunction

  function automatic void predict_table(plt_cmd_t c);
    int unsigned i;
    bit          hit;
    step_results.delete();
    hit = 1'b0;
    case (c.cmd)
      CMD_TICK: seconds_now = seconds_now + 32'd1;
      CMD_LOOKUP: begin
        for (i = 0; i < peer_count && !hit; i++) begin
          if (peer_live(i) && names_equal({peer_name_hi[i], peer_name_lo[i]}, c.name)) begin
            step_results.push_back(entry_result(KIND_FOUND, i, 1'b1));
            hit = 1'b1;
          end
        end
        if (!hit) step_results.push_back(blank_result(KIND_MISS));
      end
      CMD_LIST: begin
        for (i = 0; i < peer_count; i++) begin
          if (peer_live(i)) step_results.push_back(entry_result(KIND_LIST_ENTRY, i, 1'b0));
        end
        if (step_results.size() == 0) step_results.push_back(blank_result(KIND_LIST_EMPTY));
        else step_results[step_results.size()-1].last = 1'b1;
      end
      default: begin
        if (c.etype != cfg_etype || c.src == cfg_own_mac || c.fk == FK_TALK) begin
          step_results.push_back(blank_result(KIND_IGNORED));
        end else begin
          if (c.fk == FK_HEARTBEAT) begin
            for (i = 0; i < peer_count && !hit; i++) begin
              if (names_equal({peer_name_hi[i], peer_name_lo[i]}, c.name)) begin
                peer_beat[i] = seconds_now;
                step_results.push_back(entry_result(KIND_REFRESHED, i, 1'b1));
                hit = 1'b1;
              end
            end
          end
          if (!hit) begin
            if (peer_count >= NUM) begin
              step_results.push_back('{KIND_FULL, c.src, c.name[127:64], c.name[63:0],
                                       32'h0, 1'b1});
            end else begin
              peer_name_hi[peer_count] = c.name[127:64];
              peer_name_lo[peer_count] = c.name[63:0];
              peer_mac[peer_count]     = c.src;
              peer_beat[peer_count]    = seconds_now;
              step_results.push_back(entry_result(
                (c.fk == FK_HEARTBEAT) ? KIND_ADDED : KIND_ADDED_REPLY, peer_count, 1'b1));
              peer_count++;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic logic [127:0] make_name(int unsigned len);
    logic [127:0] n;
    int unsigned  i;
    n = '0;
    for (i = 0; i < len; i++) n[127-8*i -: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  function automatic logic [127:0] pick_name();
    logic [127:0] n;
    int unsigned  r;
    int unsigned  k;
    int unsigned  i;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, POOL - 1);
    n = name_pool[k];
    if (r < 60) return n;
    if (r < 75) begin
      // same name, junk after the terminator
      for (i = name_len[k] + 1; i < 16; i++) n[127-8*i -: 8] = 8'($urandom);
      return n;
    end
    if (r < 90) return {$urandom, $urandom, $urandom, $urandom};
    return make_name($urandom_range(0, 16));
  endfunction

  function automatic plt_cmd_t random_cmd();
    plt_cmd_t    c;
    int unsigned r;
    logic [63:0] wide;
    wide    = {$urandom, $urandom};
    c.src   = wide[47:0];
    c.etype = 16'($urandom);
    c.fk    = frame_kind_e'($urandom_range(0, 3));
    c.name  = pick_name();
    r = $urandom_range(0, 99);
    if (r < 22) c.cmd = CMD_TICK;
    else if (r < 62) c.cmd = CMD_FRAME;
    else if (r < 80) c.cmd = CMD_LOOKUP;
    else c.cmd = CMD_LIST;
    if (c.cmd == CMD_FRAME) begin
      r = $urandom_range(0, 99);
      if (r < 20) c.fk = FK_START;
      else if (r < 28) c.fk = FK_OTHER;
      else if (r < 36) c.fk = FK_TALK;
      else c.fk = FK_HEARTBEAT;
      if ($urandom_range(0, 99) < 85) c.etype = cfg_etype;
      if ($urandom_range(0, 99) < 8) c.src = cfg_own_mac;
    end
    return c;
  endfunction

  task automatic issue(input plt_cmd_t c, input logic typed, input peer_result_t want);
    int unsigned gap;
    if ($urandom_range(0, 14) == 0) back_to_back = !back_to_back;
    gap = back_to_back ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= c.cmd;
    frame_kind_i <= c.fk;
    ethertype_i  <= c.etype;
    src_mac_i    <= c.src;
    name_hi_i    <= c.name[127:64];
    name_lo_i    <= c.name[63:0];
    do @(posedge clk_i); while (busy);
    predict_table(c);
    if (typed) expected_q.push_back(want);
    else foreach (step_results[i]) expected_q.push_back(step_results[i]);
  endtask

  task automatic write_config(input logic [47:0] own, input logic [15:0] etype,
                              input logic [7:0] win);
    reg_e        regs [3];
    logic [47:0] vals [3];
    int          r;
    regs[0] = REG_OWN_MAC;
    regs[1] = REG_ETHERTYPE;
    regs[2] = REG_LIVE_WINDOW;
    vals[0] = own;
    vals[1] = {32'h0, etype};
    vals[2] = {40'h0, win};
    start <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0 || busy);
    // idle margin before the configuration writes
    repeat (NUM + 8) @(posedge clk_i);
    for (r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[r])
        REG_OWN_MAC:   cfg_own_mac = vals[r];
        REG_ETHERTYPE: cfg_etype   = vals[r][15:0];
        default:       cfg_window  = vals[r][7:0];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string fname, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none pending, expected none actual kind %0d",
                 $time, kind_o);
        error_count++;
      end else begin
        oldest = expected_q.pop_front();
        check_field("kind", 64'(oldest.kind), 64'(kind_o));
        check_field("peer_mac", 64'(oldest.mac), 64'(peer_mac_o));
        check_field("peer_name_hi", oldest.name_hi, peer_name_hi_o);
        check_field("peer_name_lo", oldest.name_lo, peer_name_lo_o);
        check_field("beat_second", 64'(oldest.beat), 64'(beat_second_o));
        check_field("last", 64'(oldest.last), 64'(last_o));
      end
    end
  end

  // no transfer of any kind for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    int unsigned p;
    int unsigned n;
    logic [63:0] wide;
    rst_ni       = 1'b0;
    start        <= 1'b0;
    cmd_i        <= '0;
    frame_kind_i <= '0;
    ethertype_i  <= '0;
    src_mac_i    <= '0;
    name_hi_i    <= '0;
    name_lo_i    <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    error_count  = 0;
    stall_cycles = 0;
    back_to_back = 1'b0;
    peer_count   = 0;
    seconds_now  = '0;
    cfg_own_mac  = '0;
    cfg_etype    = '0;
    cfg_window   = LiveWindowRst;
    for (k = 0; k < POOL; k++) begin
      name_len[k]  = (k == 0) ? 16 : (k == 1) ? 0 : $urandom_range(1, 15);
      name_pool[k] = make_name(name_len[k]);
    end

    // reset config: ethertype 0, own MAC 0, window 15
    add_row(mk_cmd(CMD_LIST, FK_START, 16'h0, 48'h0, NAME_EMPTY), 1'b1,
            blank_result(KIND_LIST_EMPTY));
    add_row(mk_cmd(CMD_LOOKUP, FK_START, 16'h0, 48'h0, NAME_ALPHA), 1'b1,
            blank_result(KIND_MISS));
    add_row(mk_cmd(CMD_FRAME, FK_HEARTBEAT, 16'h0, 48'h0, NAME_ALPHA), 1'b1,
            blank_result(KIND_IGNORED));
    add_row(mk_cmd(CMD_FRAME, FK_HEARTBEAT, 16'hFFFF, 48'h1, NAME_ALPHA), 1'b1,
            blank_result(KIND_IGNORED));
    add_row(mk_cmd(CMD_FRAME, FK_TALK, 16'h0, 48'h5, NAME_ALPHA), 1'b1,
            blank_result(KIND_IGNORED));
    add_row(mk_cmd(CMD_FRAME, FK_HEARTBEAT, 16'h0, '1, NAME_ALPHA), 1'b0, '0);
    add_row(mk_cmd(CMD_FRAME, FK_START, 16'h0, 48'h1, NAME_ONES), 1'b0, '0);
    add_row(mk_cmd(CMD_FRAME, FK_OTHER, 16'h0, 48'h2, NAME_EMPTY), 1'b0, '0);
    add_row(mk_cmd(CMD_TICK, FK_START, 16'h0, 48'h0, NAME_EMPTY), 1'b0, '0);
    add_row(mk_cmd(CMD_FRAME, FK_HEARTBEAT, 16'h0, 48'h3, NAME_ALPHA_TAIL), 1'b0, '0);
    add_row(mk_cmd(CMD_LOOKUP, FK_START, 16'h0, 48'h0, NAME_ONES), 1'b0, '0);
    add_row(mk_cmd(CMD_LOOKUP, FK_START, 16'h0, 48'h0, NAME_EMPTY), 1'b0, '0);
    add_row(mk_cmd(CMD_LOOKUP, FK_START, 16'h0, 48'h0, NAME_ALPHB), 1'b0, '0);
    add_row(mk_cmd(CMD_FRAME, FK_START, 16'h0, 48'h4, NAME_ALPHA), 1'b0, '0);
    add_row(mk_cmd(CMD_FRAME, FK_HEARTBEAT, 16'h0, 48'h6, NAME_ALPHB), 1'b0, '0);
    add_row(mk_cmd(CMD_TICK, FK_TALK, '1, '1, NAME_ONES), 1'b0, '0);
    add_row(mk_cmd(CMD_LOOKUP, FK_START, 16'h0, 48'h0, NAME_ALPHA_TAIL), 1'b0, '0);
    add_row(mk_cmd(CMD_LIST, FK_OTHER, '1, '1, NAME_ONES), 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) issue(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].want);

    for (p = 0; p < 4; p++) begin
      wide = {$urandom, $urandom};
      case (p)
        1: write_config('1, 16'hFFFF, 8'hFF);
        2: write_config(wide[47:0], 16'h88B5, 8'h00);
        3: write_config('0, 16'($urandom), 8'($urandom_range(2, 40)));
        default: ;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) issue(random_cmd(), 1'b0, '0);
    end

    start <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (NUM + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
